>>> hdl/fws_pkg.sv
`default_nettype none
package fws_pkg;

  localparam int unsigned SIZE_W   = 27;
  localparam int unsigned ZN_W     = 23;
  localparam int unsigned PROD_W   = ZN_W + 8;
  localparam int unsigned CORR_W   = 31;
  localparam int unsigned SHIFT_W  = 3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 27'd65536;
  localparam logic [7:0]        NEG_TOP    = 8'd255;
  localparam logic [7:0]        SIGN_LIMIT = 8'd127;

  localparam logic [2:0] CNT_ONE   = 3'd1;
  localparam logic [2:0] CNT_TWO   = 3'd2;
  localparam logic [2:0] CNT_THREE = 3'd3;
  localparam logic [2:0] CNT_FOUR  = 3'd4;

  typedef struct packed {
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic       neg;
  } dec_t;

endpackage : fws_pkg
`default_nettype wire

>>> hdl/fws_decode.sv
`default_nettype none
module fws_decode (
  input  wire logic [2:0]  byte_count,
  input  wire logic [31:0] raw_word,
  output fws_pkg::dec_t    dec
);

  logic [7:0] ext2;
  logic [7:0] ext3;

  assign ext3 = (raw_word[7:0]  > fws_pkg::SIGN_LIMIT) ? fws_pkg::NEG_TOP : 8'd0;
  assign ext2 = (raw_word[15:8] > fws_pkg::SIGN_LIMIT) ? fws_pkg::NEG_TOP : 8'd0;

  always_comb begin
    dec = '0;
    case (byte_count)
      fws_pkg::CNT_ONE: begin
        dec.b3  = raw_word[7:0];
        dec.b2  = ext3;
        dec.b1  = ext3;
        dec.neg = ext3[7];
      end
      fws_pkg::CNT_TWO: begin
        dec.b3  = raw_word[7:0];
        dec.b2  = raw_word[15:8];
        dec.b1  = ext2;
        dec.neg = ext2[7];
      end
      fws_pkg::CNT_THREE: begin
        dec.b3  = raw_word[7:0];
        dec.b2  = raw_word[15:8];
        dec.b1  = raw_word[23:16];
        dec.neg = raw_word[23];
      end
      fws_pkg::CNT_FOUR: begin
        dec.b3  = raw_word[7:0];
        dec.b2  = raw_word[15:8];
        dec.b1  = raw_word[23:16];
        // the top byte is dropped, only 255 marks a negative word
        dec.neg = (raw_word[31:24] == fws_pkg::NEG_TOP);
      end
      default: dec = '0;
    endcase
  end

endmodule : fws_decode
`default_nettype wire

>>> hdl/fix_word_scaler_core.sv
`default_nettype none
// Channel   Dir  Payload
// s_*       in   tdata[2:0] byte_count, tdata[34:3] raw_word
// m_*       out  tdata[31:0] scaled_value
// apb       in   addr 0x0 design_size[26:0]
//
// Five register stages: decode, multiply, two adds, shift/subtract.
// One request per cycle unless a stall at m_tready holds the pipe.
// All stages advance together; a stall at m_tready holds the whole pipe.
// Synchronous reset clears valid bits and sets design_size to 65536.
module fix_word_scaler_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // byte_count[2:0], raw_word[34:3], zero pad
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // scaled_value[31:0]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [fws_pkg::SIZE_W-1:0]  design_size;
  logic [fws_pkg::ZN_W-1:0]    zn;
  logic [2:0]                  norm_k;
  logic [fws_pkg::SHIFT_W-1:0] q_shift;
  logic [fws_pkg::CORR_W-1:0]  corr;
  logic                        cfg_wr;
  logic [fws_pkg::SIZE_W-1:0]  wsize;
  logic [2:0]                  k_next;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {5'd0, design_size};
  assign wsize  = pwdata[fws_pkg::SIZE_W-1:0];

  always_comb begin
    if (wsize[26]) begin
      k_next = 3'd4;
    end else if (wsize[25]) begin
      k_next = 3'd3;
    end else if (wsize[24]) begin
      k_next = 3'd2;
    end else if (wsize[23]) begin
      k_next = 3'd1;
    end else begin
      k_next = 3'd0;
    end
  end

  logic [fws_pkg::SIZE_W-1:0] zn_wide;
  assign zn_wide = wsize >> k_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      design_size <= fws_pkg::SIZE_RESET;
      zn          <= fws_pkg::SIZE_RESET[fws_pkg::ZN_W-1:0];
      norm_k      <= 3'd0;
      q_shift     <= 3'd4;
      corr        <= {4'd0, fws_pkg::SIZE_RESET} << 4;
    end else if (cfg_wr) begin
      design_size <= wsize;
      zn          <= zn_wide[fws_pkg::ZN_W-1:0];
      norm_k      <= k_next;
      q_shift     <= 3'd4 - k_next;
      corr        <= {8'd0, zn_wide[fws_pkg::ZN_W-1:0]} << (4'd4 + {1'b0, k_next});
    end
  end

  // pipeline
  logic en;
  logic v1, v2, v3, v4, v5;
  fws_pkg::dec_t dec, st1;
  logic [fws_pkg::PROD_W-1:0] p1, p2, p3;
  logic                       neg2, neg3, neg4;
  logic [31:0]                t3;
  logic [fws_pkg::PROD_W-1:0] p1_3;
  logic [31:0]                q4;
  logic [31:0]                r5;
  logic [31:0]                q_sh;
  logic [31:0]                sub4;

  assign en       = !v5 || m_tready;
  assign s_tready = en;
  assign m_tvalid = v5;
  assign m_tdata  = r5;

  fws_decode u_decode (
    .byte_count (s_tdata[2:0]),
    .raw_word   (s_tdata[34:3]),
    .dec        (dec)
  );

  assign q_sh = q4 >> q_shift;
  assign sub4 = neg4 ? {1'b0, corr} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1  <= dec;
      p1   <= {{fws_pkg::ZN_W{1'b0}}, st1.b1} * {8'd0, zn};
      p2   <= {{fws_pkg::ZN_W{1'b0}}, st1.b2} * {8'd0, zn};
      p3   <= {{fws_pkg::ZN_W{1'b0}}, st1.b3} * {8'd0, zn};
      neg2 <= st1.neg;
      t3   <= {9'd0, p3[fws_pkg::PROD_W-1:8]} + {1'b0, p2};
      p1_3 <= p1;
      neg3 <= neg2;
      q4   <= {8'd0, t3[31:8]} + {1'b0, p1_3};
      neg4 <= neg3;
      r5   <= q_sh - sub4;
    end
  end

`ifndef ASSERT_OFF
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v1)
    else $error("accepted request missing from stage one");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable({v1, v2, v3, v4, v5}) && $stable(r5)))
    else $error("pipeline moved during stall");

  a_norm_match: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> ({4'd0, zn} == (design_size >> norm_k)) && (zn[fws_pkg::ZN_W-1:0] == zn))
    else $error("normalized size does not match design_size");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> (q_shift + norm_k == 3'd4))
    else $error("quotient shift inconsistent with normalization");
`endif

endmodule : fix_word_scaler_core
`default_nettype wire

>>> dv/fix_word_scaler_core_tb.sv
module fix_word_scaler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CNT_ZERO  = 3'd0;
  localparam logic [2:0] CNT_FIVE  = 3'd5;
  localparam logic [2:0] CNT_SIX   = 3'd6;
  localparam logic [2:0] CNT_SEVEN = 3'd7;

  localparam logic [2:0] DESIGN_SIZE_ADDR = 3'd0;
  localparam logic [2:0] UNUSED_ADDR      = 3'd4;

  localparam logic [63:0] NORM_LIMIT = 64'd8388608;
  localparam logic [63:0] ALPHA_INIT = 64'd16;
  localparam logic [63:0] BYTE_SPAN  = 64'd256;

  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 180;
  localparam int NUM_PHASES    = 9;
  localparam int SETTLE_CYCLES = 10;

  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_TOGGLE} rx_mode_e;

  typedef struct packed {
    logic [2:0]  cnt;
    logic [31:0] word;
    logic        known;
    logic [31:0] value;
  } dir_row_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;   // byte_count[2:0], raw_word[34:3], zero pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // scaled_value[31:0]
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0]                pending_scaled[$];
  logic [fws_pkg::SIZE_W-1:0] cur_size = fws_pkg::SIZE_RESET;
  logic [31:0]                want;
  int                         fails = 0;
  int                         idle_cycles = 0;
  int                         burst_left = 0;
  bit                         gapless = 1'b0;
  bit                         hold_off_req = 1'b0;

  // extremes at the reset size (65536): alpha 16, beta 16, correction 2^20
  dir_row_t dir_rows [0:21] = '{
    '{fws_pkg::CNT_ONE,   32'h0000_0000, 1'b1, 32'd0},
    '{fws_pkg::CNT_FOUR,  32'h0010_0000, 1'b1, 32'd65536},
    '{fws_pkg::CNT_FOUR,  32'hFFF0_0000, 1'b1, -32'sd65536},
    '{fws_pkg::CNT_FOUR,  32'hFF00_0000, 1'b1, -32'sd1048576},
    '{fws_pkg::CNT_FOUR,  32'h8000_0000, 1'b1, 32'd0},
    '{CNT_ZERO,           32'hFFFF_FFFF, 1'b1, 32'd0},
    '{CNT_FIVE,           32'h1234_5678, 1'b1, 32'd0},
    '{CNT_SIX,            32'hFFFF_FFFF, 1'b1, 32'd0},
    '{CNT_SEVEN,          32'h8080_8080, 1'b1, 32'd0},
    '{fws_pkg::CNT_ONE,   32'h0000_007F, 1'b0, 32'd0},
    '{fws_pkg::CNT_ONE,   32'h0000_0080, 1'b0, 32'd0},
    '{fws_pkg::CNT_ONE,   32'hFFFF_FFFF, 1'b0, 32'd0},
    '{fws_pkg::CNT_TWO,   32'h0000_7FFF, 1'b0, 32'd0},
    '{fws_pkg::CNT_TWO,   32'h0000_8000, 1'b0, 32'd0},
    '{fws_pkg::CNT_TWO,   32'hFFFF_0001, 1'b0, 32'd0},
    '{fws_pkg::CNT_THREE, 32'h007F_FFFF, 1'b0, 32'd0},
    '{fws_pkg::CNT_THREE, 32'h0080_0000, 1'b0, 32'd0},
    '{fws_pkg::CNT_THREE, 32'hFFFF_FFFF, 1'b0, 32'd0},
    '{fws_pkg::CNT_FOUR,  32'h7FFF_FFFF, 1'b0, 32'd0},
    '{fws_pkg::CNT_FOUR,  32'h0100_0001, 1'b0, 32'd0},
    '{fws_pkg::CNT_FOUR,  32'hFEFF_FFFF, 1'b0, 32'd0},
    '{fws_pkg::CNT_FOUR,  32'hFFFF_FFFF, 1'b0, 32'd0}
  };

  fix_word_scaler_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] scale_fix_word(input logic [fws_pkg::SIZE_W-1:0] size,
                                                 input logic [2:0] cnt,
                                                 input logic [31:0] word);
    logic [63:0] z, alpha, beta, corr, b1, b2, b3, q, r;
    logic        negative;
    z = 64'(size);
    alpha = ALPHA_INIT;
    while (z >= NORM_LIMIT) begin
      z = z >> 1;
      alpha = alpha + alpha;
    end
    beta = BYTE_SPAN / alpha;
    if (beta == 64'd0) beta = 64'd1;
    corr = alpha * z;
    b3 = 64'(word[7:0]);
    b2 = 64'(word[15:8]);
    b1 = 64'(word[23:16]);
    case (cnt)
      fws_pkg::CNT_ONE: begin
        b1 = (b3 > 64'(fws_pkg::SIGN_LIMIT)) ? 64'(fws_pkg::NEG_TOP) : 64'd0;
        b2 = b1;
        negative = b1 > 64'(fws_pkg::SIGN_LIMIT);
      end
      fws_pkg::CNT_TWO: begin
        b1 = (b2 > 64'(fws_pkg::SIGN_LIMIT)) ? 64'(fws_pkg::NEG_TOP) : 64'd0;
        negative = b1 > 64'(fws_pkg::SIGN_LIMIT);
      end
      fws_pkg::CNT_THREE: negative = b1 > 64'(fws_pkg::SIGN_LIMIT);
      fws_pkg::CNT_FOUR:  negative = word[31:24] == fws_pkg::NEG_TOP;
      default:            return 32'd0;
    endcase
    q = ((((b3 * z) / BYTE_SPAN) + (b2 * z)) / BYTE_SPAN + (b1 * z)) / beta;
    r = negative ? q - corr : q;
    return r[31:0];
  endfunction

  task automatic send_word(input logic [2:0] cnt, input logic [31:0] word,
                           input logic known, input logic [31:0] value);
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, word, cnt};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_scaled.push_back(known ? value : scale_fix_word(cur_size, cnt, word));
  endtask

  task automatic pace();
    if (!gapless) begin
      if (burst_left == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_scaled.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == DESIGN_SIZE_ADDR) cur_size = data[fws_pkg::SIZE_W-1:0];
  endtask

  // stimulus
  initial begin
    int unsigned                sel;
    logic [2:0]                 cnt;
    logic [31:0]                word;
    logic [fws_pkg::SIZE_W-1:0] size;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 24);
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].cnt, dir_rows[i].word, dir_rows[i].known, dir_rows[i].value);
      pace();
    end
    s_tvalid <= 1'b0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      repeat (8) @(posedge clk);
      case (p)
        0: size = '0;
        1: size = '1;
        2: size = 27'd1;
        3: size = 27'd8388607;
        4: size = 27'd8388608;
        default: size = 27'($urandom_range(1, 134217727));
      endcase
      if (p == 2) write_reg(UNUSED_ADDR, $urandom);
      write_reg(DESIGN_SIZE_ADDR, {5'($urandom_range(0, 31)), size});
      if (p == 1 || p == 6) hold_off_req = 1'b1;
      gapless = (p == 4);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 3 && i == PHASE_ITEMS / 2) begin
          s_tvalid <= 1'b0;
          wait_drained();
        end
        sel  = $urandom_range(0, 19);
        cnt  = (sel < 3) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
        word = $urandom;
        if (sel >= 15) word[31:24] = fws_pkg::NEG_TOP;
        if (sel == 14) word = '1;
        if (sel == 13) word = '0;
        send_word(cnt, word, 1'b0, 32'd0);
        pace();
      end
      s_tvalid <= 1'b0;
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // result side back-pressure
  initial begin
    rx_mode_e mode;
    int       mode_left;
    mode = RX_ALWAYS;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(4, 64);
      end
      mode_left--;
      case (mode)
        RX_ALWAYS: m_tready <= 1'b1;
        RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
        RX_RARELY: m_tready <= ($urandom_range(0, 3) == 0);
        default:   m_tready <= ~m_tready;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_scaled.size() == 0) begin
        $error("scaled_value: expected none, got %0d", $signed(m_tdata));
        fails++;
      end else begin
        want = pending_scaled.pop_front();
        if (m_tdata !== want) begin
          $error("scaled_value: expected %0d, got %0d", $signed(want), $signed(m_tdata));
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> files.f
hdl/fws_pkg.sv
hdl/fws_decode.sv
hdl/fix_word_scaler_core.sv
dv/fix_word_scaler_core_tb.sv
